// ----- sv/fpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpsc_pkg
// Shared types and constants for the fixed-pattern ASCII/UTF-16LE scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package fpsc_pkg;

    localparam int PATTERN_LEN_DEFAULT = 68;
    localparam int PATTERN_CHARS       = 68;
    localparam int PATTERN_LEN_MAX     = 128;
    localparam int PAT_IDX_W           = $clog2(PATTERN_LEN_MAX);

    localparam logic [8*PATTERN_CHARS-1:0] PATTERN_STR =
        "X5O!P%@AP[4\\PZX54(P^)7CC)7}$EICAR-STANDARD-ANTIVIRUS-TEST-FILE!$H+H*";

    typedef struct packed {
        logic found_so_far;
        logic end_of_buffer;
    } fpsc_result_t;

    // positions past the stored string read as zero bytes
    function automatic logic [7:0] pattern_at(input logic [PAT_IDX_W-1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (int'(idx) < PATTERN_CHARS)
        begin
            ch = PATTERN_STR[8*(PATTERN_CHARS-1-int'(idx)) +: 8];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- sv/fpsc_if.sv -----
// ----------------------------------------------------------------------------
// fpsc_in_if / fpsc_out_if
// Valid/ready stream channels for scanner input bytes and scan results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fpsc_out_if;
    logic valid;
    logic ready;
    logic found_so_far;
    logic end_of_buffer;

    modport source (output valid, output found_so_far, output end_of_buffer, input ready);
    modport sink   (input valid, input found_so_far, input end_of_buffer, output ready);
endinterface

`default_nettype wire

// ----- sv/fpsc_match_core.sv -----
// ----------------------------------------------------------------------------
// fpsc_match_core
// Shift-and match vectors for the ASCII and UTF-16LE forms of the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsc_match_core #(
    parameter int PATTERN_LEN = fpsc_pkg::PATTERN_LEN_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 last_byte,
    output fpsc_pkg::fpsc_result_t    result
);
    import fpsc_pkg::*;

    localparam int UTF_LEN = 2 * PATTERN_LEN;

    logic [PATTERN_LEN-1:0] ascii_reg;
    logic [PATTERN_LEN-1:0] ascii_next;
    logic [UTF_LEN-1:0]     utf_reg;
    logic [UTF_LEN-1:0]     utf_next;
    logic                   seen_reg;
    logic                   seen_next;
    logic                   hit;

    always_comb
    begin
        ascii_next[0] = (data_byte == pattern_at(PAT_IDX_W'(0)));
        for (int k = 1; k < PATTERN_LEN; k++)
        begin
            ascii_next[k] = ascii_reg[k-1] && (data_byte == pattern_at(PAT_IDX_W'(k)));
        end
        utf_next[0] = (data_byte == pattern_at(PAT_IDX_W'(0)));
        for (int j = 1; j < UTF_LEN; j++)
        begin
            if ((j % 2) == 0)
            begin
                utf_next[j] = utf_reg[j-1] && (data_byte == pattern_at(PAT_IDX_W'(j / 2)));
            end
            else
            begin
                utf_next[j] = utf_reg[j-1] && (data_byte == 8'h00);
            end
        end
        hit       = ascii_next[PATTERN_LEN-1] || utf_next[UTF_LEN-1];
        seen_next = seen_reg || hit;
    end

    assign result.found_so_far  = seen_next;
    assign result.end_of_buffer = last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascii_reg <= '0;
            utf_reg   <= '0;
            seen_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (last_byte)
            begin
                ascii_reg <= '0;
                utf_reg   <= '0;
                seen_reg  <= 1'b0;
            end
            else
            begin
                ascii_reg <= ascii_next;
                utf_reg   <= utf_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/fpsc_out_reg.sv -----
// ----------------------------------------------------------------------------
// fpsc_out_reg
// Result register with valid flag; frees itself when the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsc_out_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire fpsc_pkg::fpsc_result_t result,
    output logic                      can_load,
    fpsc_out_if.source                out_stream
);
    import fpsc_pkg::*;

    logic         valid_reg;
    fpsc_result_t data_reg;

    assign can_load = !valid_reg || out_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_stream.valid         = valid_reg;
    assign out_stream.found_so_far  = data_reg.found_so_far;
    assign out_stream.end_of_buffer = data_reg.end_of_buffer;

endmodule

`default_nettype wire

// ----- sv/fixed_pattern_ascii_utf16_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_pattern_ascii_utf16_scanner_unit
// Scans a byte stream for the test pattern in ASCII and UTF-16LE form.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless the sink stalls; the match vectors
// update in a single compare and AND per position, the output register
// registers each accepted byte's result and frees as the sink takes it.
// Reset: clears match vectors, the sticky found flag and the output valid;
// the final byte of each buffer clears the same match state.
`default_nettype none

module fixed_pattern_ascii_utf16_scanner_unit #(
    parameter int PATTERN_LEN = fpsc_pkg::PATTERN_LEN_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    fpsc_in_if.sink      in_stream,
    fpsc_out_if.source   out_stream
);
    import fpsc_pkg::*;

    logic         can_load;
    logic         load;
    fpsc_result_t result;

    assign in_stream.ready = can_load;
    assign load            = in_stream.valid && can_load;

    fpsc_match_core #(
        .PATTERN_LEN (PATTERN_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .data_byte (in_stream.data_byte),
        .last_byte (in_stream.last_byte),
        .result    (result)
    );

    fpsc_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .result     (result),
        .can_load   (can_load),
        .out_stream (out_stream)
    );

endmodule

`default_nettype wire

// ----- bench/tb_fixed_pattern_ascii_utf16_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// tb_fixed_pattern_ascii_utf16_scanner_unit
// Streams byte buffers through the scanner and checks every result.
// Buffers carry the test string in plain and in UTF-16LE form, corrupted,
// truncated or split across a buffer boundary, and random noise. A local
// scan model tracks the byte history and the sticky found flag and
// predicts found_so_far and end_of_buffer for each accepted byte. Both
// sides of the handshake idle at random in several phases.
// ----------------------------------------------------------------------------
module tb_fixed_pattern_ascii_utf16_scanner_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fpsc_pkg::*;

    localparam int PLEN           = PATTERN_LEN_DEFAULT;
    localparam int HDEPTH         = 2 * PLEN;
    localparam int PHASE_BYTES    = 140;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic [7:0] data_byte;
        logic       last_byte;
    } scan_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    fpsc_in_if  in_stream ();
    fpsc_out_if out_stream ();

    fixed_pattern_ascii_utf16_scanner_unit #(
        .PATTERN_LEN (PLEN)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream.sink),
        .out_stream (out_stream.source)
    );

    string test_str =
        "X5O!P%@AP[4\\PZX54(P^)7CC)7}$EICAR-STANDARD-ANTIVIRUS-TEST-FILE!$H+H*";

    scan_byte_t   byte_q[$];
    fpsc_result_t verdict_q[$];
    logic [7:0]   stage_q[$];
    logic [7:0]   hist[HDEPTH];
    int           fill_count;
    logic         seen_flag;
    scan_byte_t   send_item;
    fpsc_result_t got;
    fpsc_result_t want;
    int           errors;
    int           idle_pct;
    int           stall_pct;
    int           quiet_cycles;
    int           bytes_queued;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] test_char(input int idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (idx < test_str.len())
        begin
            ch = test_str[idx];
        end
        return ch;
    endfunction

    task automatic clear_scan();
        for (int k = 0; k < HDEPTH; k++)
        begin
            hist[k] = 8'h00;
        end
        fill_count = 0;
        seen_flag  = 1'b0;
    endtask

    task automatic scan_update(input logic [7:0] b, input logic last);
        logic         ascii_hit;
        logic         wide_hit;
        fpsc_result_t r;
        for (int k = HDEPTH - 1; k > 0; k--)
        begin
            hist[k] = hist[k-1];
        end
        hist[0] = b;
        if (fill_count < HDEPTH)
        begin
            fill_count++;
        end
        ascii_hit = (fill_count >= PLEN);
        wide_hit  = (fill_count >= HDEPTH);
        for (int i = 0; i < PLEN; i++)
        begin
            if (hist[PLEN-1-i] != test_char(i))
            begin
                ascii_hit = 1'b0;
            end
            if (hist[HDEPTH-1-2*i] != test_char(i) || hist[HDEPTH-2-2*i] != 8'h00)
            begin
                wide_hit = 1'b0;
            end
        end
        if (ascii_hit || wide_hit)
        begin
            seen_flag = 1'b1;
        end
        r.found_so_far  = seen_flag;
        r.end_of_buffer = last;
        verdict_q = {verdict_q, r};
        if (last)
        begin
            clear_scan();
        end
    endtask

    task automatic stage_add(input logic [7:0] b);
        stage_q = {stage_q, b};
    endtask

    task automatic stage_pattern(input bit wide, input int first, input int count);
        for (int i = first; i < first + count; i++)
        begin
            stage_add(test_char(i));
            if (wide)
            begin
                stage_add(8'h00);
            end
        end
    endtask

    task automatic stage_noise(input int n);
        for (int i = 0; i < n; i++)
        begin
            stage_add(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic flush_stage();
        scan_byte_t item;
        for (int i = 0; i < stage_q.size(); i++)
        begin
            item.data_byte = stage_q[i];
            item.last_byte = (i == stage_q.size() - 1);
            byte_q = {byte_q, item};
        end
        bytes_queued += stage_q.size();
        stage_q.delete();
    endtask

    task automatic queue_buffer(input int pick);
        int pos;
        if (pick < 30)
        begin
            stage_noise($urandom_range(0, 20));
            stage_pattern(1'b0, 0, PLEN);
            stage_noise($urandom_range(0, 10));
            flush_stage();
        end
        else if (pick < 42)
        begin
            stage_noise($urandom_range(0, 5));
            stage_pattern(1'b1, 0, PLEN);
            stage_noise($urandom_range(0, 5));
            flush_stage();
        end
        else if (pick < 57)
        begin
            stage_noise($urandom_range(0, 20));
            pos = stage_q.size() + $urandom_range(0, PLEN - 1);
            stage_pattern(1'b0, 0, PLEN);
            stage_q[pos] = stage_q[pos] ^ 8'($urandom_range(1, 255));
            stage_noise($urandom_range(0, 10));
            flush_stage();
        end
        else if (pick < 67)
        begin
            stage_noise($urandom_range(0, 5));
            pos = stage_q.size() + $urandom_range(0, HDEPTH - 1);
            stage_pattern(1'b1, 0, PLEN);
            stage_q[pos] = stage_q[pos] ^ 8'($urandom_range(1, 255));
            stage_noise($urandom_range(0, 5));
            flush_stage();
        end
        else if (pick < 77)
        begin
            pos = $urandom_range(1, PLEN - 1);
            stage_pattern(1'b0, 0, pos);
            flush_stage();
            stage_pattern(1'b0, pos, PLEN - pos);
            stage_noise($urandom_range(0, 5));
            flush_stage();
        end
        else if (pick < 87)
        begin
            stage_pattern(1'b0, 0, $urandom_range(1, PLEN - 1));
            flush_stage();
        end
        else
        begin
            stage_noise($urandom_range(1, 40));
            flush_stage();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_stream.valid     <= 1'b0;
            in_stream.data_byte <= 8'h00;
            in_stream.last_byte <= 1'b0;
        end
        else if (!in_stream.valid || in_stream.ready)
        begin
            if (byte_q.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                send_item = byte_q.pop_front();
                in_stream.valid     <= 1'b1;
                in_stream.data_byte <= send_item.data_byte;
                in_stream.last_byte <= send_item.last_byte;
            end
            else
            begin
                in_stream.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stream.ready <= 1'b0;
        end
        else
        begin
            out_stream.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_stream.valid && in_stream.ready)
            begin
                scan_update(in_stream.data_byte, in_stream.last_byte);
            end
            if (out_stream.valid && out_stream.ready)
            begin
                got.found_so_far  = out_stream.found_so_far;
                got.end_of_buffer = out_stream.end_of_buffer;
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual found=%0b end=%0b",
                             $time, got.found_so_far, got.end_of_buffer);
                    errors++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got.found_so_far !== want.found_so_far)
                    begin
                        $display("%0t: found_so_far expected %0b actual %0b",
                                 $time, want.found_so_far, got.found_so_far);
                        errors++;
                    end
                    if (got.end_of_buffer !== want.end_of_buffer)
                    begin
                        $display("%0t: end_of_buffer expected %0b actual %0b",
                                 $time, want.end_of_buffer, got.end_of_buffer);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_stream.valid && in_stream.ready) || (out_stream.valid && out_stream.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int phase_start;
        clear_scan();
        rst_n                = 1'b0;
        in_stream.valid      = 1'b0;
        in_stream.data_byte  = 8'h00;
        in_stream.last_byte  = 1'b0;
        out_stream.ready     = 1'b0;
        idle_pct             = 0;
        stall_pct            = 0;
        errors               = 0;
        quiet_cycles         = 0;
        bytes_queued         = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            phase_start = bytes_queued;
            if (phase == 0)
            begin
                stage_add(8'h00);
                flush_stage();
                stage_add(8'hFF);
                flush_stage();
                stage_pattern(1'b0, 0, 1);
                flush_stage();
                stage_pattern(1'b0, 0, PLEN);
                flush_stage();
                stage_pattern(1'b0, 0, PLEN);
                stage_add(8'hFF);
                stage_add(8'h00);
                flush_stage();
                stage_pattern(1'b1, 0, PLEN);
                flush_stage();
                stage_pattern(1'b0, 0, PLEN / 2);
                flush_stage();
                stage_pattern(1'b0, PLEN / 2, PLEN - PLEN / 2);
                flush_stage();
                stage_pattern(1'b0, 0, PLEN - 1);
                flush_stage();
            end
            while (bytes_queued - phase_start < PHASE_BYTES)
            begin
                queue_buffer($urandom_range(0, 99));
            end
            // hold until every byte of the phase is answered
            while (byte_q.size() > 0 || in_stream.valid || verdict_q.size() > 0)
            begin
                @(negedge clk);
            end
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (byte_q.size() > 0 || verdict_q.size() > 0)
        begin
            $display("%0t: pending results expected 0 actual %0d",
                     $time, verdict_q.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/fpsc_pkg.sv
sv/fpsc_if.sv
sv/fpsc_match_core.sv
sv/fpsc_out_reg.sv
sv/fixed_pattern_ascii_utf16_scanner_unit.sv
bench/tb_fixed_pattern_ascii_utf16_scanner_unit.sv
